[sv/three_stage_pot_calibration_sequencer_unit_defines.svh]
// Assertion macros for the pot calibration sequencer.
`ifndef THREE_STAGE_POT_CALIBRATION_SEQUENCER_UNIT_DEFINES_SVH
`define THREE_STAGE_POT_CALIBRATION_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define CPSCS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cpscs: same-cycle check failed");

// Next-cycle implication, sampled on aclk, off while in reset.
`define CPSCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cpscs: next-cycle check failed");

`endif

[sv/cpscs_pkg.sv]
// Shared types and codes for the pot calibration sequencer.
`default_nettype none
package cpscs_pkg;

    localparam int WIPER_MAX_DEFAULT = 127;
    localparam int SENSOR_COUNT      = 48;

    localparam int JOB_VAL_W   = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [15:0] TARGET_RESET = 16'd24620;
    localparam logic [11:0] FAULT_RESET  = 12'd3722;
    localparam logic [16:0] ERR_ALL_ONES = 17'h1FFFF;

    // register indexes
    localparam logic REG_TARGET = 1'b0;
    localparam logic REG_FAULT  = 1'b1;

    // input kinds
    localparam logic ACT_START  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // result commands
    localparam logic [2:0] CMD_SELECT   = 3'd0;
    localparam logic [2:0] CMD_DESELECT = 3'd1;
    localparam logic [2:0] CMD_MODE     = 3'd2;
    localparam logic [2:0] CMD_WIPER    = 3'd3;
    localparam logic [2:0] CMD_REQUEST  = 3'd4;
    localparam logic [2:0] CMD_DONE     = 3'd5;
    localparam logic [2:0] CMD_FAULT    = 3'd6;

    localparam logic [1:0] POT_COARSE = 2'd0;
    localparam logic [1:0] POT_MEDIUM = 2'd1;
    localparam logic [1:0] POT_FINE   = 2'd2;

    // job kinds passed from front to back
    localparam logic [2:0] JOB_START_SEL = 3'd0;
    localparam logic [2:0] JOB_START_DES = 3'd1;
    localparam logic [2:0] JOB_STEP      = 3'd2;
    localparam logic [2:0] JOB_NEXT      = 3'd3;
    localparam logic [2:0] JOB_FAULT     = 3'd4;
    localparam logic [2:0] JOB_DONE      = 3'd5;

    typedef struct packed {
        logic [2:0]           kind;
        logic [1:0]           pot;
        logic [JOB_VAL_W-1:0] v0;
        logic [JOB_VAL_W-1:0] v1;
        logic [JOB_VAL_W-1:0] v2;
    } cpscs_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } cpscs_qstat_t;

endpackage
`default_nettype wire

[sv/cpscs_front.sv]
// Front part: accepts items, runs the sweep state and issues jobs.
`default_nettype none
module cpscs_front
    import cpscs_pkg::*;
#(
    parameter int WIPER_MAX = WIPER_MAX_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        in_action,
    input  wire logic [5:0]  in_sensor,
    input  wire logic [11:0] in_sample,
    input  wire cpscs_qstat_t qstat,
    output logic             push,
    output cpscs_job_t       job
);

    localparam int STEP_W = $clog2(WIPER_MAX + 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(WIPER_MAX);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_COARSE = 3'd1;
    localparam logic [2:0] PH_FCHECK = 3'd2;
    localparam logic [2:0] PH_MEDIUM = 3'd3;
    localparam logic [2:0] PH_FINE   = 3'd4;

    logic [15:0]       target_reg;
    logic [11:0]       fault_reg;
    logic [2:0]        phase_reg, phase_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [STEP_W-1:0] bc_reg, bc_next;
    logic [STEP_W-1:0] bm_reg, bm_next;
    logic [STEP_W-1:0] bf_reg, bf_next;
    logic [16:0]       least_reg, least_next;

    logic              accept;
    logic [15:0]       s16;
    logic [15:0]       diff;
    logic              below, at_end, finished, better;
    logic [STEP_W-1:0] step_prev, best, step_inc, bf_new;
    logic [1:0]        sweep_pot;

    assign in_ready = !qstat.full;
    assign accept   = in_valid && in_ready;

    assign s16       = {in_sample, 4'b0000};
    assign below     = s16 < target_reg;
    assign at_end    = step_reg >= STEP_LAST;
    assign finished  = below || at_end;
    assign step_prev = (step_reg != '0) ? step_reg - STEP_W'(1) : '0;
    assign best      = below ? step_prev : step_reg;
    assign step_inc  = step_reg + STEP_W'(1);
    assign diff      = (s16 >= target_reg) ? s16 - target_reg : target_reg - s16;
    assign better    = {1'b0, diff} < least_reg;
    assign bf_new    = better ? step_reg : bf_reg;
    assign sweep_pot = (phase_reg == PH_COARSE) ? POT_COARSE : POT_MEDIUM;

    always_comb begin
        phase_next = phase_reg;
        step_next  = step_reg;
        bc_next    = bc_reg;
        bm_next    = bm_reg;
        bf_next    = bf_reg;
        least_next = least_reg;
        push       = 1'b0;
        job        = '0;
        if (accept) begin
            if (in_action == ACT_START) begin
                push       = 1'b1;
                job.kind   = ({1'b0, in_sensor} < 7'(SENSOR_COUNT)) ? JOB_START_SEL
                                                                     : JOB_START_DES;
                job.v0     = JOB_VAL_W'(in_sensor);
                bc_next    = '0;
                bm_next    = '0;
                bf_next    = '0;
                least_next = ERR_ALL_ONES;
                phase_next = PH_COARSE;
                step_next  = '0;
            end else begin
                case (phase_reg)
                    PH_COARSE, PH_MEDIUM: begin
                        push = 1'b1;
                        if (phase_reg == PH_COARSE) begin
                            bc_next = best;
                        end else begin
                            bm_next = best;
                        end
                        if (!finished) begin
                            step_next = step_inc;
                            job.kind  = JOB_STEP;
                            job.pot   = sweep_pot;
                            job.v0    = JOB_VAL_W'(step_inc);
                        end else if (phase_reg == PH_COARSE && best == STEP_LAST) begin
                            phase_next = PH_FCHECK;
                            job.kind   = JOB_STEP;
                            job.pot    = POT_COARSE;
                            job.v0     = JOB_VAL_W'(best);
                        end else begin
                            job.kind  = JOB_NEXT;
                            job.pot   = sweep_pot;
                            job.v0    = JOB_VAL_W'(best);
                            step_next = '0;
                            if (phase_reg == PH_COARSE) begin
                                phase_next = PH_MEDIUM;
                            end else begin
                                phase_next = PH_FINE;
                                least_next = ERR_ALL_ONES;
                            end
                        end
                    end
                    PH_FCHECK: begin
                        push = 1'b1;
                        if (in_sample > fault_reg) begin
                            job.kind   = JOB_FAULT;
                            phase_next = PH_IDLE;
                        end else begin
                            job.kind   = JOB_STEP;
                            job.pot    = POT_MEDIUM;
                            phase_next = PH_MEDIUM;
                            step_next  = '0;
                        end
                    end
                    PH_FINE: begin
                        push    = 1'b1;
                        bf_next = bf_new;
                        if (better) begin
                            least_next = {1'b0, diff};
                        end
                        if (at_end) begin
                            job.kind   = JOB_DONE;
                            job.v0     = JOB_VAL_W'(bc_reg);
                            job.v1     = JOB_VAL_W'(bm_reg);
                            job.v2     = JOB_VAL_W'(bf_new);
                            phase_next = PH_IDLE;
                        end else begin
                            step_next = step_inc;
                            job.kind  = JOB_STEP;
                            job.pot   = POT_FINE;
                            job.v0    = JOB_VAL_W'(step_inc);
                        end
                    end
                    default: begin
                        push = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= TARGET_RESET;
            fault_reg  <= FAULT_RESET;
            phase_reg  <= PH_IDLE;
            step_reg   <= '0;
            bc_reg     <= '0;
            bm_reg     <= '0;
            bf_reg     <= '0;
            least_reg  <= ERR_ALL_ONES;
        end else begin
            if (cfg_we && cfg_index == REG_TARGET) begin
                target_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == REG_FAULT) begin
                fault_reg <= cfg_wdata[11:0];
            end
            phase_reg <= phase_next;
            step_reg  <= step_next;
            bc_reg    <= bc_next;
            bm_reg    <= bm_next;
            bf_reg    <= bf_next;
            least_reg <= least_next;
        end
    end

endmodule
`default_nettype wire

[sv/cpscs_queue.sv]
// Job queue between the front and back parts.
`default_nettype none
module cpscs_queue
    import cpscs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire cpscs_job_t  push_job,
    input  wire logic        pop,
    output cpscs_job_t       head,
    output cpscs_qstat_t     qstat
);

    cpscs_job_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign qstat.full  = cnt_reg == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign qstat.empty = cnt_reg == '0;
    assign head        = mem_reg[rd_reg];
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;

    always_comb begin
        wr_next  = do_push ? wr_reg + QPTR_W'(1) : wr_reg;
        rd_next  = do_pop ? rd_reg + QPTR_W'(1) : rd_reg;
        cnt_next = cnt_reg + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

[sv/cpscs_back.sv]
// Back part: expands each job into its result items, one per cycle while out_ready is high.
`default_nettype none
module cpscs_back
    import cpscs_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire cpscs_job_t   head,
    input  wire cpscs_qstat_t qstat,
    output logic              pop,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [2:0]        out_command,
    output logic [1:0]        out_pot,
    output logic [6:0]        out_value,
    output logic              out_last
);

    logic [3:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [2:0] cmd_reg;
    logic [1:0] pot_reg;
    logic [6:0] val_reg;
    logic       last_reg;

    logic       load;
    logic [2:0] r_cmd;
    logic [1:0] r_pot;
    logic [6:0] r_val;
    logic       r_last;
    logic [3:0] idx_m1, idx_m4;

    function automatic logic [6:0] clamp(input logic [JOB_VAL_W-1:0] v);
        clamp = (v > JOB_VAL_W'(127)) ? 7'd127 : v[6:0];
    endfunction

    assign idx_m1 = idx_reg - 4'd1;
    assign idx_m4 = idx_reg - 4'd4;

    always_comb begin
        r_cmd  = CMD_REQUEST;
        r_pot  = POT_COARSE;
        r_val  = 7'd0;
        r_last = 1'b0;
        case (head.kind)
            JOB_START_SEL, JOB_START_DES: begin
                case (idx_reg)
                    4'd0: begin
                        if (head.kind == JOB_START_SEL) begin
                            r_cmd = CMD_SELECT;
                            r_val = clamp(head.v0);
                        end else begin
                            r_cmd = CMD_DESELECT;
                        end
                    end
                    4'd1, 4'd2, 4'd3: begin
                        r_cmd = CMD_MODE;
                        r_pot = idx_m1[1:0];
                        r_val = 7'd1;
                    end
                    4'd4, 4'd5, 4'd6: begin
                        r_cmd = CMD_WIPER;
                        r_pot = idx_m4[1:0];
                    end
                    4'd7: begin
                        r_cmd = CMD_WIPER;
                    end
                    default: begin
                        r_last = 1'b1;
                    end
                endcase
            end
            JOB_STEP: begin
                if (idx_reg == 4'd0) begin
                    r_cmd = CMD_WIPER;
                    r_pot = head.pot;
                    r_val = clamp(head.v0);
                end else begin
                    r_last = 1'b1;
                end
            end
            JOB_NEXT: begin
                case (idx_reg)
                    4'd0: begin
                        r_cmd = CMD_WIPER;
                        r_pot = head.pot;
                        r_val = clamp(head.v0);
                    end
                    4'd1: begin
                        r_cmd = CMD_WIPER;
                        r_pot = head.pot + 2'd1;
                    end
                    default: begin
                        r_last = 1'b1;
                    end
                endcase
            end
            JOB_FAULT: begin
                if (idx_reg == 4'd0) begin
                    r_cmd = CMD_DESELECT;
                end else begin
                    r_cmd  = CMD_FAULT;
                    r_last = 1'b1;
                end
            end
            JOB_DONE: begin
                case (idx_reg)
                    4'd0, 4'd6: begin
                        r_cmd = CMD_WIPER;
                        r_pot = POT_FINE;
                        r_val = clamp(head.v2);
                    end
                    4'd1: begin
                        r_cmd = CMD_MODE;
                        r_pot = POT_COARSE;
                    end
                    4'd2: begin
                        r_cmd = CMD_WIPER;
                        r_pot = POT_COARSE;
                        r_val = clamp(head.v0);
                    end
                    4'd3: begin
                        r_cmd = CMD_MODE;
                        r_pot = POT_MEDIUM;
                    end
                    4'd4: begin
                        r_cmd = CMD_WIPER;
                        r_pot = POT_MEDIUM;
                        r_val = clamp(head.v1);
                    end
                    4'd5: begin
                        r_cmd = CMD_MODE;
                        r_pot = POT_FINE;
                    end
                    default: begin
                        r_cmd  = CMD_DONE;
                        r_last = 1'b1;
                    end
                endcase
            end
            default: begin
                r_last = 1'b1;
            end
        endcase
    end

    assign load = !valid_reg || out_ready;
    assign pop  = load && !qstat.empty && r_last;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = !qstat.empty;
            if (!qstat.empty) begin
                idx_next = r_last ? 4'd0 : idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load && !qstat.empty) begin
            cmd_reg  <= r_cmd;
            pot_reg  <= r_pot;
            val_reg  <= r_val;
            last_reg <= r_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_command = cmd_reg;
    assign out_pot     = pot_reg;
    assign out_value   = val_reg;
    assign out_last    = last_reg;

endmodule
`default_nettype wire

[sv/three_stage_pot_calibration_sequencer_unit.sv]
// Top level of the three-pot calibration sequencer.
//
//  channel  dir  tdata                         tuser      tlast
//  s_       in   sensor[5:0] sample[17:6]      action     -
//  m_       out  pot[1:0] value[8:2]           command    last
//  cfg_     in   write enable, index, data     -          -
//
// The front takes one item per cycle while the four-entry job queue has room.
// The back sends one result per cycle while m_tready is high; a start yields
// 9 results, a sweep step 2, a sweep hand-over 3, the final commit 8. Reset
// (aresetn low at a clock edge) clears the queue and sweep state, resets the
// registers. A stalled m_ side fills the queue and then lowers s_tready.
`default_nettype none
`include "three_stage_pot_calibration_sequencer_unit_defines.svh"
module three_stage_pot_calibration_sequencer_unit
    import cpscs_pkg::*;
#(
    parameter int WIPER_MAX = WIPER_MAX_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // sensor[5:0], sample[17:6], zero pad
    input  wire logic        s_tuser,   // action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // pot[1:0], value[8:2], zero pad
    output logic [2:0]       m_tuser,   // command
    output logic             m_tlast
);

    cpscs_job_t   push_job, head;
    cpscs_qstat_t qstat;
    logic         push, pop;
    logic [1:0]   out_pot;
    logic [6:0]   out_value;

    cpscs_front #(
        .WIPER_MAX(WIPER_MAX)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .in_sensor (s_tdata[5:0]),
        .in_sample (s_tdata[17:6]),
        .qstat     (qstat),
        .push      (push),
        .job       (push_job)
    );

    cpscs_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    cpscs_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head),
        .qstat       (qstat),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_command (m_tuser),
        .out_pot     (out_pot),
        .out_value   (out_value),
        .out_last    (m_tlast)
    );

    assign m_tdata = {7'd0, out_value, out_pot};

    `CPSCS_ASSERT_NOW(a_no_push_when_full, qstat.full, !push)
    `CPSCS_ASSERT_NEXT(a_idle_stays_idle, !m_tvalid && qstat.empty, !m_tvalid)
    `CPSCS_ASSERT_NEXT(a_start_queues_job, s_tvalid && s_tready && s_tuser == ACT_START,
                       !qstat.empty)

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the three-pot calibration sequencer.
`timescale 1ns / 1ps
module testbench;
    import cpscs_pkg::*;

    localparam int          CLK_HALF      = 5;
    localparam int          RESET_CYCLES  = 6;
    localparam int          QUIET_CYCLES  = 40;
    localparam int          STALL_LIMIT   = 2000;
    localparam int          PHASE_ITEMS   = 6;
    localparam int          UNTYPED       = -1;
    localparam logic [1:0]  NO_POT        = 2'd0;
    localparam int unsigned MODE_VOLATILE = 1;
    localparam int unsigned MODE_NONVOL   = 0;
    localparam logic [1:0]  ALL_POTS [3]  = '{POT_COARSE, POT_MEDIUM, POT_FINE};

    typedef enum logic [2:0] {
        SW_IDLE, SW_COARSE, SW_FAULT_CHECK, SW_MEDIUM, SW_FINE
    } sweep_phase_e;

    typedef struct {
        logic [2:0] cmd;
        logic [1:0] pot;
        logic [6:0] value;
        logic       last;
    } pot_cmd_t;

    typedef struct packed {
        logic        act;
        logic [5:0]  sensor;
        logic [11:0] sample;
        int          count;
        logic [2:0]  cmd;
        logic [1:0]  pot;
        logic [6:0]  value;
    } stim_row_t;

    // reset config: sample 1538 is below target, 1539 is not
    localparam stim_row_t DIRECTED_ROWS [22] = '{
        '{ACT_SAMPLE,  0, 4095, 0,       CMD_SELECT,   NO_POT,      0},
        '{ACT_START,  63, 4095, 9,       CMD_DESELECT, NO_POT,      0},
        '{ACT_START,  48,    0, 9,       CMD_DESELECT, NO_POT,      0},
        '{ACT_START,  47,    0, 9,       CMD_SELECT,   NO_POT,     47},
        '{ACT_START,   0,    0, 9,       CMD_SELECT,   NO_POT,      0},
        '{ACT_SAMPLE, 63, 4095, 2,       CMD_WIPER,    POT_COARSE,  1},
        '{ACT_SAMPLE,  0, 1539, 2,       CMD_WIPER,    POT_COARSE,  2},
        '{ACT_SAMPLE,  0, 1538, 3,       CMD_WIPER,    POT_COARSE,  1},
        '{ACT_SAMPLE,  0,    0, 3,       CMD_WIPER,    POT_MEDIUM,  0},
        '{ACT_SAMPLE,  0, 1538, 2,       CMD_WIPER,    POT_FINE,    1},
        '{ACT_SAMPLE,  0, 1539, UNTYPED, CMD_SELECT,   NO_POT,      0},
        '{ACT_SAMPLE,  0, 1539, UNTYPED, CMD_SELECT,   NO_POT,      0},
        '{ACT_SAMPLE,  0, 4095, UNTYPED, CMD_SELECT,   NO_POT,      0},
        '{ACT_SAMPLE,  0,    0, UNTYPED, CMD_SELECT,   NO_POT,      0},
        '{ACT_START,  21, 4095, 9,       CMD_SELECT,   NO_POT,     21},
        '{ACT_SAMPLE,  7, 3000, UNTYPED, CMD_SELECT,   NO_POT,      0},
        '{ACT_SAMPLE,  7, 2048, UNTYPED, CMD_SELECT,   NO_POT,      0},
        '{ACT_SAMPLE,  7, 1538, UNTYPED, CMD_SELECT,   NO_POT,      0},
        '{ACT_SAMPLE,  7, 4095, UNTYPED, CMD_SELECT,   NO_POT,      0},
        '{ACT_SAMPLE,  7,    1, UNTYPED, CMD_SELECT,   NO_POT,      0},
        '{ACT_SAMPLE,  7, 1540, UNTYPED, CMD_SELECT,   NO_POT,      0},
        '{ACT_SAMPLE,  7, 1537, UNTYPED, CMD_SELECT,   NO_POT,      0}
    };

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = 24'd0;  // sensor[5:0], sample[17:6], zero pad
    logic        s_tuser   = 1'b0;   // action
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;            // pot[1:0], value[8:2], zero pad
    logic [2:0]  m_tuser;            // command
    logic        m_tlast;

    // sequencer model state
    logic [15:0]  target_x16  = TARGET_RESET;
    logic [11:0]  fault_level = FAULT_RESET;
    sweep_phase_e sweep_phase = SW_IDLE;
    int unsigned  sweep_step  = 0;
    int unsigned  coarse_pick = 0;
    int unsigned  medium_pick = 0;
    int unsigned  fine_pick   = 0;
    logic [16:0]  fine_err    = ERR_ALL_ONES;

    pot_cmd_t    new_cmds[$];
    pot_cmd_t    pending_cmds[$];
    int          errors       = 0;
    int unsigned items_sent   = 0;
    int unsigned rx_hold      = 0;
    int unsigned quiet_cycles = 0;
    bit          tx_steady    = 1'b0;
    bit          rx_steady    = 1'b0;

    three_stage_pot_calibration_sequencer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #CLK_HALF aclk = ~aclk;

    function automatic void add_cmd(logic [2:0] cmd, logic [1:0] pot, int unsigned value);
        pot_cmd_t c;
        c.cmd   = cmd;
        c.pot   = pot;
        c.value = (value > 127) ? 7'd127 : 7'(value);
        c.last  = 1'b0;
        new_cmds.push_back(c);
    endfunction

    function automatic void open_sweep(logic [1:0] pot, sweep_phase_e ph);
        sweep_phase = ph;
        sweep_step  = 0;
        add_cmd(CMD_WIPER, pot, 0);
        add_cmd(CMD_REQUEST, NO_POT, 0);
    endfunction

    function automatic void advance_sequencer(logic act, logic [5:0] sensor, logic [11:0] sample);
        int unsigned s16, best, err;
        logic [1:0]  pot;
        bit          ended;
        new_cmds.delete();
        s16 = 32'(sample) * 16;
        if (act == ACT_START) begin
            if (sensor < SENSOR_COUNT) begin
                add_cmd(CMD_SELECT, NO_POT, sensor);
            end else begin
                add_cmd(CMD_DESELECT, NO_POT, 0);
            end
            foreach (ALL_POTS[i]) add_cmd(CMD_MODE, ALL_POTS[i], MODE_VOLATILE);
            foreach (ALL_POTS[i]) add_cmd(CMD_WIPER, ALL_POTS[i], 0);
            coarse_pick = 0;
            medium_pick = 0;
            fine_pick   = 0;
            fine_err    = ERR_ALL_ONES;
            open_sweep(POT_COARSE, SW_COARSE);
        end else if (sweep_phase == SW_COARSE || sweep_phase == SW_MEDIUM) begin
            pot = (sweep_phase == SW_COARSE) ? POT_COARSE : POT_MEDIUM;
            if (s16 < target_x16) begin
                best  = (sweep_step > 0) ? sweep_step - 1 : 0;
                ended = 1'b1;
            end else begin
                best  = sweep_step;
                ended = (sweep_step >= WIPER_MAX_DEFAULT);
            end
            if (pot == POT_COARSE) coarse_pick = best;
            else medium_pick = best;
            if (!ended) begin
                sweep_step++;
                add_cmd(CMD_WIPER, pot, sweep_step);
                add_cmd(CMD_REQUEST, NO_POT, 0);
            end else begin
                add_cmd(CMD_WIPER, pot, best);
                if (pot == POT_COARSE && best == WIPER_MAX_DEFAULT) begin
                    sweep_phase = SW_FAULT_CHECK;
                    add_cmd(CMD_REQUEST, NO_POT, 0);
                end else if (pot == POT_COARSE) begin
                    open_sweep(POT_MEDIUM, SW_MEDIUM);
                end else begin
                    fine_err = ERR_ALL_ONES;
                    open_sweep(POT_FINE, SW_FINE);
                end
            end
        end else if (sweep_phase == SW_FAULT_CHECK) begin
            if (sample > fault_level) begin
                add_cmd(CMD_DESELECT, NO_POT, 0);
                add_cmd(CMD_FAULT, NO_POT, 0);
                sweep_phase = SW_IDLE;
            end else begin
                open_sweep(POT_MEDIUM, SW_MEDIUM);
            end
        end else if (sweep_phase == SW_FINE) begin
            err = (s16 >= target_x16) ? s16 - target_x16 : target_x16 - s16;
            if (err < fine_err) begin
                fine_err  = 17'(err);
                fine_pick = sweep_step;
            end
            if (sweep_step >= WIPER_MAX_DEFAULT) begin
                add_cmd(CMD_WIPER, POT_FINE, fine_pick);
                add_cmd(CMD_MODE, POT_COARSE, MODE_NONVOL);
                add_cmd(CMD_WIPER, POT_COARSE, coarse_pick);
                add_cmd(CMD_MODE, POT_MEDIUM, MODE_NONVOL);
                add_cmd(CMD_WIPER, POT_MEDIUM, medium_pick);
                add_cmd(CMD_MODE, POT_FINE, MODE_NONVOL);
                add_cmd(CMD_WIPER, POT_FINE, fine_pick);
                add_cmd(CMD_DONE, NO_POT, 0);
                sweep_phase = SW_IDLE;
            end else begin
                sweep_step++;
                add_cmd(CMD_WIPER, POT_FINE, sweep_step);
                add_cmd(CMD_REQUEST, NO_POT, 0);
            end
        end
        if (new_cmds.size() > 0) new_cmds[new_cmds.size() - 1].last = 1'b1;
        foreach (new_cmds[i]) pending_cmds.push_back(new_cmds[i]);
    endfunction

    // sample that steers the sweep in progress; hurry drives it toward idle
    function automatic logic [11:0] pick_sample(int unsigned coarse_stop,
                                                 int unsigned medium_stop, bit hurry);
        int unsigned low_above, high_below, stop_pct;
        int v;
        low_above  = (32'(target_x16) + 15) / 16;
        high_below = (target_x16 == 0) ? 0 : (32'(target_x16) - 1) / 16;
        case (sweep_phase)
            SW_COARSE, SW_MEDIUM: begin
                stop_pct = hurry ? 100 : ((sweep_phase == SW_COARSE) ? coarse_stop : medium_stop);
                if (target_x16 != 0 && (low_above > 4095 || $urandom_range(0, 99) < stop_pct))
                    return 12'($urandom_range(0, high_below));
                return 12'($urandom_range(low_above, 4095));
            end
            SW_FAULT_CHECK: begin
                if (fault_level != 12'hFFF && (hurry || $urandom_range(0, 1) == 1))
                    return 12'($urandom_range(32'(fault_level) + 1, 4095));
                return 12'($urandom_range(0, 32'(fault_level)));
            end
            SW_FINE: begin
                if ($urandom_range(0, 4) == 0) return 12'($urandom);
                v = int'(target_x16 / 16) + int'($urandom_range(0, 6)) - 3;
                if (v < 0) v = 0;
                if (v > 4095) v = 4095;
                return 12'(v);
            end
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic void check_result();
        pot_cmd_t want;
        if (pending_cmds.size() == 0) begin
            $error("unexpected item: command %0d pot %0d value %0d",
                   m_tuser, m_tdata[1:0], m_tdata[8:2]);
            errors++;
            return;
        end
        want = pending_cmds.pop_front();
        if (m_tuser !== want.cmd) begin
            $error("command: expected %0d, got %0d", want.cmd, m_tuser);
            errors++;
        end
        if (m_tdata[1:0] !== want.pot) begin
            $error("pot: expected %0d, got %0d", want.pot, m_tdata[1:0]);
            errors++;
        end
        if (m_tdata[8:2] !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, m_tdata[8:2]);
            errors++;
        end
        if (m_tlast !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, m_tlast);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        int unsigned draw;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end else if (m_tvalid && m_tready) begin
            check_result();
            draw = rx_steady ? 0 : $urandom_range(0, 4);
            rx_hold  <= draw;
            m_tready <= (draw == 0);
        end else if (rx_hold != 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= (rx_hold == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(logic act, logic [5:0] sensor, logic [11:0] sample);
        int unsigned gap;
        gap = tx_steady ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {6'b0, sample, sensor};
        do @(posedge aclk); while (!s_tready);
        if (act == ACT_START || sweep_phase != SW_IDLE) items_sent++;
        advance_sequencer(act, sensor, sample);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    task automatic program_regs(logic [15:0] target, logic [11:0] fault);
        cfg_we    <= 1'b1;
        cfg_index <= REG_TARGET;
        cfg_wdata <= target;
        @(posedge aclk);
        cfg_index <= REG_FAULT;
        cfg_wdata <= {4'b0, fault};
        @(posedge aclk);
        cfg_we      <= 1'b0;
        target_x16  = target;
        fault_level = fault;
    endtask

    task automatic finish_calibration();
        while (sweep_phase != SW_IDLE)
            send_item(ACT_SAMPLE, 6'($urandom), pick_sample(100, 100, 1'b1));
    endtask

    task automatic run_sequence();
        int unsigned kind, coarse_stop, medium_stop, limit, n;
        kind      = $urandom_range(0, 99);
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
        if (kind < 10) begin
            // noise: raw items, samples while idle among them
            repeat ($urandom_range(1, 4))
                send_item(1'($urandom), 6'($urandom), 12'($urandom));
            return;
        end
        coarse_stop = (kind < 25) ? 0 : $urandom_range(15, 60);
        medium_stop = $urandom_range(15, 60);
        limit       = (kind < 45) ? $urandom_range(1, 4) : $urandom_range(5, 12);
        send_item(ACT_START, 6'($urandom), 12'($urandom));
        n = 0;
        while (sweep_phase != SW_IDLE && n < limit) begin
            send_item(ACT_SAMPLE, 6'($urandom), pick_sample(coarse_stop, medium_stop, 1'b0));
            n++;
        end
    endtask

    initial begin
        stim_row_t   row;
        int unsigned mark;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED_ROWS[i]) begin
            row = DIRECTED_ROWS[i];
            send_item(row.act, row.sensor, row.sample);
            if (row.count != UNTYPED) begin
                if (new_cmds.size() != row.count || (row.count > 0 &&
                    (new_cmds[0].cmd != row.cmd || new_cmds[0].pot != row.pot ||
                     new_cmds[0].value != row.value))) begin
                    $error("directed row %0d: table and prediction disagree", i);
                    errors++;
                end
            end
        end
        finish_calibration();

        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) begin
                wait_idle();
                case (ph)
                    1: program_regs(16'h0000, 12'h000);
                    2: program_regs(16'hFFFF, 12'hFFF);
                    3: program_regs(16'($urandom_range(3200, 48000)), 12'($urandom));
                    default: program_regs(16'($urandom), 12'($urandom));
                endcase
            end
            mark = items_sent;
            while (items_sent - mark < PHASE_ITEMS) run_sequence();
        end

        wait_idle();
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
